>>> hdl/clpm_pkg.sv
// Shared types and constants for the clip list position mapper.
// No dependencies; imported by every module of the block.
package clpm_pkg;

    localparam int MAX_CLIPS_DEFAULT = 16;
    localparam int POS_W             = 31;
    localparam int EDIT_W            = 35;
    localparam int TOTAL_W           = 36;
    localparam int CIDX_W            = 5;
    localparam int FUNC_W            = 2;
    localparam int ENTRY_W           = 4;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_MAP   = 2'd1,
        FUNC_TOTAL = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic [POS_W-1:0] clip_start;
        logic [POS_W-1:0] clip_end;
    } clip_entry_t;

    typedef struct packed {
        logic               found;
        logic [POS_W-1:0]   file_position;
        logic [CIDX_W-1:0]  clip_index;
        logic [TOTAL_W-1:0] total_length;
    } result_t;

endpackage

>>> hdl/clpm_table.sv
// Clip table: synchronous memory of clip entries with a registered read port.
// Per-entry valid bits clear the table at reset. Depends on clpm_pkg.
module clpm_table
    import clpm_pkg::*;
#(
    parameter int MAX_CLIPS = MAX_CLIPS_DEFAULT,
    parameter int IDX_W     = (MAX_CLIPS > 1) ? $clog2(MAX_CLIPS) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  clip_entry_t       wr_data,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output clip_entry_t       rd_data
);

    clip_entry_t              mem [MAX_CLIPS];
    logic [MAX_CLIPS-1:0]     valid_reg;
    logic                     rd_valid_reg;
    clip_entry_t              rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> hdl/clpm_walker.sv
// Command decoder and list walker: writes entries, walks the table one entry a cycle.
// Depends on clpm_pkg; drives the clpm_table ports.
module clpm_walker
    import clpm_pkg::*;
#(
    parameter int MAX_CLIPS = MAX_CLIPS_DEFAULT,
    parameter int IDX_W     = (MAX_CLIPS > 1) ? $clog2(MAX_CLIPS) : 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [FUNC_W-1:0]   func,
    input  logic [ENTRY_W-1:0]  entry_index,
    input  logic [POS_W-1:0]    clip_start,
    input  logic [POS_W-1:0]    clip_end,
    input  logic [EDIT_W-1:0]   edit_position,
    output logic                wr_en,
    output logic [IDX_W-1:0]    wr_addr,
    output clip_entry_t         wr_data,
    output logic                rd_en,
    output logic [IDX_W-1:0]    rd_addr,
    input  clip_entry_t         rd_data,
    output logic                res_valid,
    input  logic                res_ready,
    output result_t             res
);

    localparam int CNT_W  = $clog2(MAX_CLIPS + 1);
    localparam int SUM_W  = 32 + $clog2(MAX_CLIPS);
    localparam int ACC_W  = (SUM_W > TOTAL_W) ? SUM_W : TOTAL_W;
    localparam logic [ACC_W-1:0] ACC_TOTAL_MAX = ACC_W'(TOTAL_MAX);

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [ACC_W-1:0]     pos_reg, pos_next;
    logic [EDIT_W-1:0]    ep_reg, ep_next;
    logic                 map_reg, map_next;
    result_t              res_reg, res_next;

    logic                 accept;
    logic                 start_walk;
    logic                 term;
    logic                 hit;
    logic                 last;
    logic                 finish;
    logic [POS_W:0]       len;
    logic [ACC_W-1:0]     sum;
    logic [ACC_W-1:0]     total_raw;
    logic [CNT_W-1:0]     k_inc;

    assign accept     = in_valid && in_ready;
    assign start_walk = accept && (func == FUNC_MAP || func == FUNC_TOTAL);

    assign term  = (rd_data.clip_end == '0);
    assign len   = {1'b0, rd_data.clip_end} - {1'b0, rd_data.clip_start} + (POS_W+1)'(1);
    assign sum   = pos_reg + ACC_W'(len);
    assign hit   = map_reg && !term && (ACC_W'(ep_reg) < sum);
    assign k_inc = k_reg + CNT_W'(1);
    assign last  = (k_inc == CNT_W'(MAX_CLIPS));
    assign finish = term || hit || last;
    assign total_raw = term ? pos_reg : sum;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_walk)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (finish)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = '0;
        res_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                rd_en    = start_walk;
            end
            ST_WALK:
            begin
                rd_en   = !finish;
                rd_addr = IDX_W'(k_inc);
            end
            ST_HOLD:
            begin
                res_valid = res_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = IDX_W'(entry_index);
        wr_data = '{clip_start: clip_start, clip_end: clip_end};
        case (func) inside
            FUNC_WRITE:
            begin
                wr_en = accept && (32'(entry_index) < 32'(MAX_CLIPS)) && (clip_end >= clip_start);
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        k_next   = k_reg;
        pos_next = pos_reg;
        ep_next  = ep_reg;
        map_next = map_reg;
        res_next = res_reg;
        if (start_walk)
        begin
            k_next   = '0;
            pos_next = '0;
            ep_next  = edit_position;
            map_next = (func == FUNC_MAP);
        end
        else if (state_reg == ST_WALK)
        begin
            if (finish)
            begin
                res_next = '0;
                if (map_reg)
                begin
                    res_next.found      = hit;
                    res_next.clip_index = (term || hit) ? CIDX_W'(k_reg) : CIDX_W'(k_inc);
                    if (hit)
                    begin
                        res_next.file_position = rd_data.clip_start + ep_reg[POS_W-1:0]
                                                 - pos_reg[POS_W-1:0];
                    end
                end
                else
                begin
                    res_next.total_length = (total_raw > ACC_TOTAL_MAX) ? TOTAL_MAX
                                            : total_raw[TOTAL_W-1:0];
                end
            end
            else
            begin
                k_next   = k_inc;
                pos_next = sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        pos_reg <= pos_next;
        ep_reg  <= ep_next;
        map_reg <= map_next;
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

>>> hdl/clip_list_position_mapper.sv
// Top level of the clip list position mapper: walker, clip table and output register.
// Depends on clpm_pkg, clpm_table and clpm_walker.
//
// Usage:
//   Input channel in_valid/in_ready carries one item: func, entry_index,
//   clip_start, clip_end, edit_position. func 0 writes a clip entry (no
//   result), func 1 maps an edited position, func 2 returns the total length;
//   func 3 is dropped. Output channel out_valid/out_ready carries found,
//   file_position, clip_index and total_length.
//   A write needs no walk and leaves in_ready high. A query walks the table
//   from entry 0, one entry per cycle through the single read port of the
//   clip memory, and stops at the first entry whose end is zero, at a match,
//   or after MAX_CLIPS entries. in_ready rises again once the result moves
//   into the output register, so no new item is taken while a query is busy.
//   Reset clears the table at once through per-entry valid bits; no clearing
//   pass is needed.
//   While out_ready is low a result holds in the output register; a second
//   finished result holds in the walker and stalls further input.
module clip_list_position_mapper
    import clpm_pkg::*;
#(
    parameter int MAX_CLIPS = MAX_CLIPS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [FUNC_W-1:0]   func,
    input  logic [ENTRY_W-1:0]  entry_index,
    input  logic [POS_W-1:0]    clip_start,
    input  logic [POS_W-1:0]    clip_end,
    input  logic [EDIT_W-1:0]   edit_position,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                found,
    output logic [POS_W-1:0]    file_position,
    output logic [CIDX_W-1:0]   clip_index,
    output logic [TOTAL_W-1:0]  total_length
);

    localparam int IDX_W = (MAX_CLIPS > 1) ? $clog2(MAX_CLIPS) : 1;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    clip_entry_t       wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    clip_entry_t       rd_data;
    logic              res_valid;
    logic              res_ready;
    result_t           res;

    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    clpm_table #(
        .MAX_CLIPS (MAX_CLIPS),
        .IDX_W     (IDX_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    clpm_walker #(
        .MAX_CLIPS (MAX_CLIPS),
        .IDX_W     (IDX_W)
    ) u_walker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .entry_index   (entry_index),
        .clip_start    (clip_start),
        .clip_end      (clip_end),
        .edit_position (edit_position),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res)
    );

    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid     = out_valid_reg;
    assign found         = out_reg.found;
    assign file_position = out_reg.file_position;
    assign clip_index    = out_reg.clip_index;
    assign total_length  = out_reg.total_length;

    a_res_only_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_ready)
        else $error("walker released a result into a full output register");

    a_no_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !res_valid)
        else $error("result released right after an input item was accepted");

    a_no_accept_while_walking: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en && !in_ready |-> !wr_en)
        else $error("table write during a walk");

    a_found_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (total_length == '0))
        else $error("map result carries a total length");

endmodule
